@@ design/wbh_pkg.sv @@
package wbh_pkg;

  localparam int unsigned Rounds = 10;
  localparam int unsigned RndW = 4;

  typedef logic [63:0] row_t;
  typedef row_t [7:0] mat_t;

  // Control from the sequencer to the round unit.
  typedef struct packed {
    logic        load;     // start a block: key = H, data = M ^ H
    logic        step;     // perform one round
    logic [RndW-1:0] rnd;  // index of the round being performed
  } rnd_ctrl_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h18,8'h23,8'hC6,8'hE8,8'h87,8'hB8,8'h01,8'h4F,8'h36,8'hA6,8'hD2,8'hF5,8'h79,8'h6F,8'h91,8'h52,
      8'h60,8'hBC,8'h9B,8'h8E,8'hA3,8'h0C,8'h7B,8'h35,8'h1D,8'hE0,8'hD7,8'hC2,8'h2E,8'h4B,8'hFE,8'h57,
      8'h15,8'h77,8'h37,8'hE5,8'h9F,8'hF0,8'h4A,8'hDA,8'h58,8'hC9,8'h29,8'h0A,8'hB1,8'hA0,8'h6B,8'h85,
      8'hBD,8'h5D,8'h10,8'hF4,8'hCB,8'h3E,8'h05,8'h67,8'hE4,8'h27,8'h41,8'h8B,8'hA7,8'h7D,8'h95,8'hD8,
      8'hFB,8'hEE,8'h7C,8'h66,8'hDD,8'h17,8'h47,8'h9E,8'hCA,8'h2D,8'hBF,8'h07,8'hAD,8'h5A,8'h83,8'h33,
      8'h63,8'h02,8'hAA,8'h71,8'hC8,8'h19,8'h49,8'hD9,8'hF2,8'hE3,8'h5B,8'h88,8'h9A,8'h26,8'h32,8'hB0,
      8'hE9,8'h0F,8'hD5,8'h80,8'hBE,8'hCD,8'h34,8'h48,8'hFF,8'h7A,8'h90,8'h5F,8'h20,8'h68,8'h1A,8'hAE,
      8'hB4,8'h54,8'h93,8'h22,8'h64,8'hF1,8'h73,8'h12,8'h40,8'h08,8'hC3,8'hEC,8'hDB,8'hA1,8'h8D,8'h3D,
      8'h97,8'h00,8'hCF,8'h2B,8'h76,8'h82,8'hD6,8'h1B,8'hB5,8'hAF,8'h6A,8'h50,8'h45,8'hF3,8'h30,8'hEF,
      8'h3F,8'h55,8'hA2,8'hEA,8'h65,8'hBA,8'h2F,8'hC0,8'hDE,8'h1C,8'hFD,8'h4D,8'h92,8'h75,8'h06,8'h8A,
      8'hB2,8'hE6,8'h0E,8'h1F,8'h62,8'hD4,8'hA8,8'h96,8'hF9,8'hC5,8'h25,8'h59,8'h84,8'h72,8'h39,8'h4C,
      8'h5E,8'h78,8'h38,8'h8C,8'hD1,8'hA5,8'hE2,8'h61,8'hB3,8'h21,8'h9C,8'h1E,8'h43,8'hC7,8'hFC,8'h04,
      8'h51,8'h99,8'h6D,8'h0D,8'hFA,8'hDF,8'h7E,8'h24,8'h3B,8'hAB,8'hCE,8'h11,8'h8F,8'h4E,8'hB7,8'hEB,
      8'h3C,8'h81,8'h94,8'hF7,8'hB9,8'h13,8'h2C,8'hD3,8'hE7,8'h6E,8'hC4,8'h03,8'h56,8'h44,8'h7F,8'hA9,
      8'h2A,8'hBB,8'hC1,8'h53,8'hDC,8'h0B,8'h9D,8'h6C,8'h31,8'h74,8'hF6,8'h46,8'hAC,8'h89,8'h14,8'hE1,
      8'h16,8'h3A,8'h69,8'h09,8'h70,8'hB6,8'hD0,8'hED,8'hCC,8'h42,8'h98,8'hA4,8'h28,8'h5C,8'hF8,8'h86
    };
    return t[a];
  endfunction

  // Doubling in GF(2^8) modulo x^8+x^4+x^3+x^2+1.
  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1D : 8'h00);
  endfunction

  // Byte j of a row, column 0 in the top bits.
  function automatic logic [7:0] byte_at(input row_t r, input int unsigned j);
    return r[63-8*j -: 8];
  endfunction

  // Substitution, column shift and row mixing of a whole matrix.
  function automatic mat_t round_body(input mat_t s);
    logic [7:0] t [8][8];
    logic [7:0] x1, x2, x4, x8, acc;
    logic [3:0] c;
    mat_t o;
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++)
        t[i][j] = sbox(byte_at(s[(i + 8 - j) % 8], j));
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++) begin
        acc = 8'h00;
        for (int k = 0; k < 8; k++) begin
          unique case ((j + 8 - k) % 8)
            0, 1, 3: c = 4'h1;
            2:       c = 4'h4;
            4:       c = 4'h8;
            5:       c = 4'h5;
            6:       c = 4'h2;
            default: c = 4'h9;
          endcase
          x1 = t[i][k];
          x2 = xt(x1);
          x4 = xt(x2);
          x8 = xt(x4);
          acc ^= (c[0] ? x1 : 8'h00) ^ (c[1] ? x2 : 8'h00) ^
                 (c[2] ? x4 : 8'h00) ^ (c[3] ? x8 : 8'h00);
        end
        o[i][63-8*j -: 8] = acc;
      end
    return o;
  endfunction

endpackage

@@ design/wbh_round.sv @@
module wbh_round (
  input  logic               clk_i,
  input  wbh_pkg::rnd_ctrl_t ctrl_i,
  input  wbh_pkg::mat_t      chain_i,
  input  wbh_pkg::mat_t      msg_i,
  output wbh_pkg::mat_t      dat_o
);
  import wbh_pkg::*;

  mat_t key_q, key_d, dat_q, dat_d, kr;
  logic [63:0] rc;

  always_comb begin
    for (int j = 0; j < 8; j++)
      rc[63-8*j -: 8] = sbox(8'({ctrl_i.rnd, 3'(j)}));
    kr = round_body(key_q);
    kr[0] = kr[0] ^ rc;
    key_d = key_q;
    dat_d = dat_q;
    if (ctrl_i.load) begin
      key_d = chain_i;
      for (int i = 0; i < 8; i++) dat_d[i] = chain_i[i] ^ msg_i[i];
    end else if (ctrl_i.step) begin
      key_d = kr;
      dat_d = round_body(dat_q);
      for (int i = 0; i < 8; i++) dat_d[i] = dat_d[i] ^ kr[i];
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    dat_q <= dat_d;
  end

  assign dat_o = dat_q;
endmodule

@@ design/whirlpool_block_hasher_core.sv @@
// Whirlpool compression core. Message words of 64 bits come in eight per
// 512-bit block, first byte in bits 63..56; first_of_message (tuser bit 0)
// clears the chaining value and restarts the block. After the eighth word the
// block is enciphered by one shared round unit, one round per cycle; the core
// stalls its input while the block is loaded, enciphered and folded into the
// chaining value. If the eighth word carries tlast the eight digest words then
// stream out, one per cycle as the sink accepts them, with the word index in
// tuser and tlast on the eighth.
module whirlpool_block_hasher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // msg_word
  input  logic        s_axis_tuser,   // first_of_message
  input  logic        s_axis_tlast,   // last_of_message
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_word
  output logic [7:0]  m_axis_tuser,   // digest_index[2:0], zero fill
  output logic        m_axis_tlast    // digest_last
);
  import wbh_pkg::*;

  localparam logic [1:0] StIn = 2'd0, StLoad = 2'd1, StRnd = 2'd2, StOut = 2'd3;

  logic [1:0]      st_q, st_d;
  logic [2:0]      wc_q, idx_q;
  logic [RndW-1:0] rnd_q;
  logic            last_q, upd_q;
  mat_t            chain_q, buf_q, dat;
  rnd_ctrl_t       ctrl;
  logic            acc_in, acc_out;

  assign s_axis_tready = (st_q == StIn);
  assign acc_in  = s_axis_tvalid && s_axis_tready;
  assign acc_out = m_axis_tvalid && m_axis_tready;

  assign ctrl.load = (st_q == StLoad);
  assign ctrl.step = (st_q == StRnd) && !upd_q;
  assign ctrl.rnd  = rnd_q;

  wbh_round u_round (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .chain_i(chain_q),
    .msg_i  (buf_q),
    .dat_o  (dat)
  );

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIn:   if (acc_in && (s_axis_tuser || wc_q == 3'd7) && wc_q == 3'd7) st_d = StLoad;
      StLoad: st_d = StRnd;
      StRnd:  if (upd_q) st_d = last_q ? StOut : StIn;
      default: if (acc_out && idx_q == 3'd7) st_d = StIn;
    endcase
    // A first flag always lands the word at slot zero, so it never ends a block.
    if (st_q == StIn && acc_in && s_axis_tuser) st_d = StIn;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= StIn;
      wc_q    <= '0;
      rnd_q   <= '0;
      upd_q   <= 1'b0;
      last_q  <= 1'b0;
      idx_q   <= '0;
      chain_q <= '0;
    end else begin
      st_q <= st_d;
      if (acc_in) begin
        if (s_axis_tuser) begin
          chain_q <= '0;
          wc_q    <= 3'd1;
        end else begin
          wc_q <= wc_q + 3'd1;
        end
        last_q <= s_axis_tlast;
      end
      if (st_q == StLoad) begin
        rnd_q <= '0;
        upd_q <= 1'b0;
      end
      if (ctrl.step) begin
        rnd_q <= rnd_q + RndW'(1);
        if (rnd_q == RndW'(Rounds - 1)) upd_q <= 1'b1;
      end
      if (st_q == StRnd && upd_q) begin
        for (int i = 0; i < 8; i++) chain_q[i] <= chain_q[i] ^ dat[i] ^ buf_q[i];
        idx_q <= '0;
      end
      if (acc_out) idx_q <= idx_q + 3'd1;
    end
  end

  // Block buffer: payload only.
  always_ff @(posedge clk_i) begin
    if (acc_in) buf_q[s_axis_tuser ? 3'd0 : wc_q] <= s_axis_tdata;
  end

  assign m_axis_tvalid = (st_q == StOut);
  assign m_axis_tdata  = chain_q[idx_q];
  assign m_axis_tuser  = {5'd0, idx_q};
  assign m_axis_tlast  = (idx_q == 3'd7);
endmodule

@@ design/wbh_checker.sv @@
module wbh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic [7:0]  m_axis_tuser,
  input logic        m_axis_tlast
);
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("input open while digest out");
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[2:0] == 3'd7)))
    else $error("tlast mismatch");
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=>
      (m_axis_tvalid && m_axis_tuser[2:0] == $past(m_axis_tuser[2:0]) + 3'd1))
    else $error("index did not advance");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("digest changed under stall");
endmodule

bind whirlpool_block_hasher_core wbh_checker u_wbh_checker (.*);
